// ===== hw/rtl/lbp8_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp8_pkg
// Shared constants, payload types and neighbour tables for the 3x3 local
// binary pattern block.
// ----------------------------------------------------------------------------
package lbp8_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 8;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 13;
    // common width for column-against-width compares
    localparam int CMP_W     = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
    localparam int NB_N      = 8;

    // window row / column of neighbour i (row 0 = upper line, col 0 = left)
    localparam logic [1:0] NB_ROW [0:NB_N-1] = '{2'd0, 2'd1, 2'd2, 2'd2,
                                                 2'd2, 2'd1, 2'd0, 2'd0};
    localparam logic [1:0] NB_COL [0:NB_N-1] = '{2'd0, 2'd0, 2'd0, 2'd1,
                                                 2'd2, 2'd2, 2'd2, 2'd1};
    localparam logic [1:0] WIN_FIRST = 2'd0;
    localparam logic [1:0] WIN_LAST  = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             flush;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pattern_code;
        logic             frame_end;
    } t_result;

    // classified word passed from front to back
    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [COL_W-1:0] col;
        logic             primed;
        logic [NB_N-1:0]  mask;
        logic             last;
    } t_cls;

endpackage

// ===== hw/rtl/lbp8_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp8_front
// Tracks input and output raster positions, decides whether a word yields a
// code, and builds the border mask of valid neighbours.
// ----------------------------------------------------------------------------
module lbp8_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [10:0]             i_image_width,
    input  logic [12:0]             i_image_height,
    input  logic                    i_fire,
    input  lbp8_pkg::t_in_item      i_item,
    output lbp8_pkg::t_cls          o_cls
);
    import lbp8_pkg::*;

    logic [COL_W-1:0]    r_in_col,  n_in_col;
    logic [1:0]          r_in_row,  n_in_row;
    logic [COL_W-1:0]    r_out_col, n_out_col;
    logic [HEIGHT_W-1:0] r_out_row, n_out_row;

    logic [CMP_W-1:0]    w_eff;
    logic [HEIGHT_W:0]   h_eff;
    logic                in_col_end;
    logic                out_col_end;
    logic                out_row_end;
    logic                at_left;
    logic                at_top;
    logic                primed;
    logic                last;
    logic [NB_N-1:0]     mask;

    always_comb begin
        if (i_image_width == '0) begin
            w_eff = CMP_W'(1);
        end else if (CMP_W'(i_image_width) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = CMP_W'(i_image_width);
        end
        h_eff = (i_image_height == '0) ? (HEIGHT_W+1)'(1) : {1'b0, i_image_height};
    end

    assign in_col_end  = (CMP_W'(r_in_col) + CMP_W'(1)) >= w_eff;
    assign out_col_end = (CMP_W'(r_out_col) + CMP_W'(1)) >= w_eff;
    assign out_row_end = ({1'b0, r_out_row} + (HEIGHT_W+1)'(1)) >= h_eff;
    assign at_left     = (r_out_col == '0);
    assign at_top      = (r_out_row == '0);
    assign primed      = (r_in_row == 2'd2) || ((r_in_row == 2'd1) && (r_in_col != '0));
    assign last        = out_row_end && out_col_end;

    always_comb begin
        for (int i = 0; i < NB_N; i++) begin
            mask[i] = !((NB_COL[i] == WIN_FIRST) && at_left)
                   && !((NB_COL[i] == WIN_LAST)  && out_col_end)
                   && !((NB_ROW[i] == WIN_FIRST) && at_top)
                   && !((NB_ROW[i] == WIN_LAST)  && out_row_end);
        end
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (in_col_end) begin
            n_in_col = '0;
            if (r_in_row != 2'd2) begin
                n_in_row = r_in_row + 2'd1;
            end
        end else begin
            n_in_col = r_in_col + COL_W'(1);
        end
        if (primed) begin
            if (last) begin
                // frame done: rewind everything to pixel zero
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (out_col_end) begin
                n_out_col = '0;
                n_out_row = r_out_row + HEIGHT_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_fire) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    always_comb begin
        o_cls.px     = i_item.flush ? '0 : i_item.pixel;
        o_cls.col    = r_in_col;
        o_cls.primed = primed;
        o_cls.mask   = mask;
        o_cls.last   = last;
    end

endmodule

// ===== hw/rtl/lbp8_cls_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp8_cls_fifo
// Four-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module lbp8_cls_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lbp8_pkg::t_cls  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output lbp8_pkg::t_cls  o_data,
    output logic            o_empty
);
    import lbp8_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_cls             r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/lbp8_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp8_back
// Line store access, 3x3 window shift, neighbour compare and result queue.
// ----------------------------------------------------------------------------
module lbp8_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lbp8_pkg::t_cls     i_cls,
    input  logic               i_cls_empty,
    output logic               o_cls_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output lbp8_pkg::t_result  o_result
);
    import lbp8_pkg::*;

    localparam int LINE_W = 2 * PIX_W;
    localparam int ODEPTH = 4;
    localparam int OPTR_W = $clog2(ODEPTH);

    // {upper, middle} line entry per column
    logic [LINE_W-1:0]  r_mem [MAX_WIDTH];
    logic [LINE_W-1:0]  r_rd;
    logic               r_fwd;
    logic [LINE_W-1:0]  r_fwd_data;

    logic               r_b2_valid;
    t_cls               r_b2;
    logic               r_b3_valid;
    logic               r_b3_primed;
    logic               r_b3_last;
    logic [NB_N-1:0]    r_b3_mask;
    logic [PIX_W-1:0]   r_win [3][3];

    t_result            r_obuf [ODEPTH];
    logic [OPTR_W-1:0]  r_owr_ptr;
    logic [OPTR_W-1:0]  r_ord_ptr;
    logic [OPTR_W:0]    r_ocount;

    logic               out_full;
    logic               out_push;
    logic               out_pop;
    logic               adv;
    logic               pop_q;
    logic               mem_we;
    logic [LINE_W-1:0]  line;
    logic [PIX_W-1:0]   up_px;
    logic [PIX_W-1:0]   mid_px;
    logic [LINE_W-1:0]  wr_line;
    logic [NB_N-1:0]    code;

    assign out_full = (r_ocount == (OPTR_W+1)'(ODEPTH));
    assign out_pop  = i_pop && (r_ocount != '0);
    assign adv      = !(r_b3_valid && r_b3_primed && out_full);
    assign out_push = r_b3_valid && r_b3_primed && !out_full;
    assign pop_q    = adv && !i_cls_empty;
    assign mem_we   = adv && r_b2_valid;
    assign o_cls_pop = pop_q;

    // bypass the line written by the word just ahead at the same column
    assign line    = r_fwd ? r_fwd_data : r_rd;
    assign up_px   = line[LINE_W-1:PIX_W];
    assign mid_px  = line[PIX_W-1:0];
    assign wr_line = {mid_px, r_b2.px};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_b2.col] <= wr_line;
        end
        if (pop_q) begin
            r_rd       <= r_mem[i_cls.col];
            r_fwd_data <= wr_line;
            r_b2       <= i_cls;
        end
        if (adv) begin
            r_b3_primed <= r_b2.primed;
            r_b3_last   <= r_b2.last;
            r_b3_mask   <= r_b2.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_fwd      <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else begin
            if (pop_q) begin
                r_fwd <= mem_we && (r_b2.col == i_cls.col);
            end
            if (adv) begin
                r_b2_valid <= !i_cls_empty;
                r_b3_valid <= r_b2_valid;
            end
            if (mem_we) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= up_px;
                r_win[1][2] <= mid_px;
                r_win[2][2] <= r_b2.px;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NB_N; i++) begin
            code[i] = r_b3_mask[i] && (r_win[NB_ROW[i]][NB_COL[i]] <= r_win[1][1]);
        end
    end

    // result queue
    assign o_empty  = (r_ocount == '0);
    assign o_result = r_obuf[r_ord_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr_ptr <= '0;
            r_ord_ptr <= '0;
            r_ocount  <= '0;
        end else begin
            if (out_push) begin
                r_owr_ptr <= r_owr_ptr + OPTR_W'(1);
            end
            if (out_pop) begin
                r_ord_ptr <= r_ord_ptr + OPTR_W'(1);
            end
            case ({out_push, out_pop})
                2'b10:   r_ocount <= r_ocount + (OPTR_W+1)'(1);
                2'b01:   r_ocount <= r_ocount - (OPTR_W+1)'(1);
                default: r_ocount <= r_ocount;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_obuf[r_owr_ptr].pattern_code <= code;
            r_obuf[r_owr_ptr].frame_end    <= r_b3_last;
        end
    end

endmodule

// ===== hw/rtl/lbp_8_neighbour_code_top.sv =====
`timescale 1ns / 1ps
// Order: a pixel's code is ready once the word one row plus one pixel later
//   is accepted and has passed the front queue, line store read and window compare.
// Throughput: one word per cycle while the result queue is not full; the single-port-read line store sets it.
// Reset: synchronous, active low; clears positions, window and queues and
//   loads width 640 and height 480. Line store contents are left as they are.
// ----------------------------------------------------------------------------
// lbp_8_neighbour_code_top
// 3x3 eight-neighbour local binary pattern on a raster pixel stream, with an
// APB-style register port for the image size.
// ----------------------------------------------------------------------------
module lbp_8_neighbour_code_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  lbp8_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output lbp8_pkg::t_result   o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import lbp8_pkg::*;

    localparam logic                REG_IMAGE_WIDTH  = 1'b0;
    localparam logic                REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [WIDTH_W-1:0]  RST_WIDTH        = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT       = HEIGHT_W'(480);

    logic [WIDTH_W-1:0]  r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;
    logic                cfg_wr;
    logic                fire;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    t_cls                front_cls;
    t_cls                q_cls;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_WIDTH;
            r_image_height <= RST_HEIGHT;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[HEIGHT_W-1:0];
                default:          r_image_width  <= r_image_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = 32'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = 32'(r_image_height);
            default:          prdata = '0;
        endcase
    end

    assign full = q_full;
    assign fire = push && !q_full;

    lbp8_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_fire         (fire),
        .i_item         (i_item),
        .o_cls          (front_cls)
    );

    lbp8_cls_fifo u_cls_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (front_cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_cls),
        .o_empty (q_empty)
    );

    lbp8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls       (q_cls),
        .i_cls_empty (q_empty),
        .o_cls_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule
